[rtl/core/ebsg_pkg.sv]
// shared types, constants and the control store for the emergency brake speed governor
// no dependencies; imported by every module of the block
package ebsg_pkg;

    // field widths
    localparam int DIST_W     = 12;
    localparam int WHEEL_W    = 12;
    localparam int SPEED_W    = 16;
    localparam int FACTOR_W   = 8;
    localparam int SLOPE_W    = 23;
    localparam int MARGIN_W   = 12;
    localparam int FPROD_W    = FACTOR_W + WHEEL_W;
    localparam int PROD_W     = SLOPE_W + MARGIN_W;
    localparam int DIV_NUM_W  = 24;
    localparam int DIV_DEN_W  = 17;
    localparam int STEP_W     = 4;
    localparam int CFG_ADDR_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_BRAKE_FACTOR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WARN_FACTOR  = 2'd1;

    localparam logic [FACTOR_W-1:0] BRAKE_FACTOR_RST = 8'd1;
    localparam logic [FACTOR_W-1:0] WARN_FACTOR_RST  = 8'd2;

    localparam logic [SPEED_W-1:0]   SPEED_MAX       = 16'hFFFF;
    // 65536 * 100: the smallest product whose scaled speed no longer fits
    localparam logic [PROD_W-1:0]    SPEED_SAT_LIMIT = 35'd6553600;
    localparam logic [DIV_DEN_W-1:0] SLOPE_SCALE     = 17'd100;
    localparam logic [7:0]           SLOPE_SCALE_X2  = 8'd200;

    // divide by 100 as divide by 4 then multiply by ceil(2^26 / 25) and shift;
    // exact for every product below the saturation limit
    localparam int SCALE_IN_W  = 21;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 26;
    localparam int RPROD_W     = SCALE_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] SLOPE_RECIP = 22'd2684355;

    typedef enum logic [1:0] {
        ZONE_CLEAR = 2'd0,
        ZONE_WARN  = 2'd1,
        ZONE_STOP  = 2'd2,
        ZONE_NONE  = 2'd3
    } zone_t;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_WAIT,
        UOP_MUL,
        UOP_SAT,
        UOP_ZONE,
        UOP_MULS,
        UOP_LDQ,
        UOP_LDS,
        UOP_DIV,
        UOP_WB,
        UOP_OUT
    } uop_t;

    // jump conditions
    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_IS_CLEAR,
        JC_NOT_WARN,
        JC_NO_GAP,
        JC_DIV_BUSY,
        JC_OUT_FREE
    } jcond_t;

    typedef struct packed {
        uop_t              op;
        jcond_t            cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic is_clear;
        logic not_warn;
        logic no_gap;
        logic div_busy;
        logic out_free;
    } dp_flags_t;

    // program addresses
    localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SAT  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ZONE = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MULS = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LDQ  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LDS  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIV  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_WB   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_HOLD = 4'd10;

    // control store
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            STEP_WAIT: w = '{UOP_WAIT, JC_NO_INPUT,  STEP_WAIT};
            STEP_MUL:  w = '{UOP_MUL,  JC_NEVER,     STEP_WAIT};
            STEP_SAT:  w = '{UOP_SAT,  JC_NEVER,     STEP_WAIT};
            STEP_ZONE: w = '{UOP_ZONE, JC_IS_CLEAR,  STEP_LDS};
            STEP_MULS: w = '{UOP_MULS, JC_NOT_WARN,  STEP_OUT};
            STEP_LDQ:  w = '{UOP_LDQ,  JC_ALWAYS,    STEP_OUT};
            STEP_LDS:  w = '{UOP_LDS,  JC_NO_GAP,    STEP_OUT};
            STEP_DIV:  w = '{UOP_DIV,  JC_DIV_BUSY,  STEP_DIV};
            STEP_WB:   w = '{UOP_WB,   JC_NEVER,     STEP_WAIT};
            STEP_OUT:  w = '{UOP_OUT,  JC_OUT_FREE,  STEP_WAIT};
            STEP_HOLD: w = '{UOP_NOP,  JC_ALWAYS,    STEP_OUT};
            default:   w = '{UOP_NOP,  JC_ALWAYS,    STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/ebsg_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// depends on ebsg_pkg for operand widths
module ebsg_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ebsg_pkg::DIV_NUM_W-1:0] num,
    input  logic [ebsg_pkg::DIV_DEN_W-1:0] den,
    output logic                           busy,
    output logic [ebsg_pkg::DIV_NUM_W-1:0] quot
);
    import ebsg_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W-1:0] r_reg, r_next;
    logic [DIV_DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W:0]   trial;

    always_comb begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        trial    = {r_reg, q_reg[DIV_NUM_W-1]} - {1'b0, d_reg};
        if (start) begin
            q_next   = num;
            r_next   = '0;
            d_next   = den;
            cnt_next = CNT_W'(DIV_NUM_W);
        end else if (cnt_reg != '0) begin
            // no borrow means the shifted remainder covered the divisor
            if (!trial[DIV_DEN_W]) begin
                r_next = trial[DIV_DEN_W-1:0];
            end else begin
                r_next = {r_reg[DIV_DEN_W-2:0], q_reg[DIV_NUM_W-1]};
            end
            q_next   = {q_reg[DIV_NUM_W-2:0], ~trial[DIV_DEN_W]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

endmodule

[rtl/core/ebsg_seq.sv]
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on ebsg_pkg for the control word, flag bundle and program
module ebsg_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  ebsg_pkg::dp_flags_t flags,
    output ebsg_pkg::uword_t    uword
);
    import ebsg_pkg::*;

    logic [STEP_W-1:0] pc_reg, pc_next;
    logic              take;

    assign uword = ucode_rom(pc_reg);

    always_comb begin
        case (uword.cond)
            JC_NEVER:     take = 1'b0;
            JC_ALWAYS:    take = 1'b1;
            JC_NO_INPUT:  take = !flags.in_valid;
            JC_IS_CLEAR:  take = flags.is_clear;
            JC_NOT_WARN:  take = flags.not_warn;
            JC_NO_GAP:    take = flags.no_gap;
            JC_DIV_BUSY:  take = flags.div_busy;
            JC_OUT_FREE:  take = flags.out_free;
            default:      take = 1'b1;
        endcase
        pc_next = take ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/core/emergency_brake_speed_governor.sv]
// top level of the emergency brake speed governor: datapath, state and result register
// depends on ebsg_pkg, ebsg_seq and ebsg_div
//
// One beat in gives one beat out. A small microcoded sequencer walks a fixed
// program over a plain datapath: it latches the beat (loading a new speed
// command if one comes with it), averages the wheel speeds, forms the braking
// and warning distances (factor times average, saturated to 16 bits), picks
// the zone and updates the buzzer and speed state. In the clear zone it
// recomputes the stored slope, speed * 100 / gap rounded half up, on a
// 24-step serial divider; in the warning zone it scales the slope by the
// margin over the braking distance and divides by 100 with a reciprocal
// multiply in one step. A clear zone with a positive gap runs the divider and
// writes the quotient back as the slope; with no gap the slope is zeroed. The
// warning zone loads the scaled speed, which the braking and unmatched zones
// skip. While an older result waits on m_ready, each try to load the result
// register passes through a hold step. One item is in work at a time; s_ready
// is high only while the sequencer waits for input. Results sit in an output
// register, so the next beat can be taken while a result still waits on m_ready.
// Factor registers are written through the configuration port; the user must
// write them only while the block is idle; the block does not enforce it.
module emergency_brake_speed_governor (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [ebsg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ebsg_pkg::FACTOR_W-1:0]     cfg_wdata,
    // input beat
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ebsg_pkg::DIST_W-1:0]       s_front_distance,
    input  logic [ebsg_pkg::WHEEL_W-1:0]      s_right_wheel_speed,
    input  logic [ebsg_pkg::WHEEL_W-1:0]      s_left_wheel_speed,
    input  logic                              s_command_valid,
    input  logic [ebsg_pkg::SPEED_W-1:0]      s_new_speed,
    // result beat
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ebsg_pkg::SPEED_W-1:0]      m_drive_speed,
    output logic [1:0]                        m_zone,
    output logic                              m_buzzer_on,
    output logic                              m_stop_request,
    output logic [ebsg_pkg::SPEED_W-1:0]      m_braking_distance,
    output logic [ebsg_pkg::SPEED_W-1:0]      m_warning_distance
);
    import ebsg_pkg::*;

    // sequencer link
    uword_t    uword;
    dp_flags_t flags;

    // configuration
    logic [FACTOR_W-1:0] brake_factor_reg, warn_factor_reg;

    // latched input beat
    logic [DIST_W-1:0]  front_reg,  front_next;
    logic [WHEEL_W-1:0] right_reg,  right_next;
    logic [WHEEL_W-1:0] left_reg,   left_next;

    // working values
    logic [FPROD_W-1:0] bprod_reg, bprod_next;
    logic [FPROD_W-1:0] wprod_reg, wprod_next;
    logic [SPEED_W-1:0] brake_reg, brake_next;
    logic [SPEED_W-1:0] warn_reg,  warn_next;
    logic [PROD_W-1:0]  prod_reg,  prod_next;
    zone_t              zone_reg,  zone_next;
    logic               stop_reg,  stop_next;

    // persistent state
    logic [SPEED_W-1:0] speed_reg,  speed_next;
    logic [SLOPE_W-1:0] slope_reg,  slope_next;
    logic [DIST_W-1:0]  object_reg, object_next;
    logic               buzzer_reg, buzzer_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [SPEED_W-1:0] m_speed_reg, m_brake_reg, m_warn_reg;
    zone_t              m_zone_reg;
    logic               m_buzzer_reg, m_stop_reg;

    // divider
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_quot;

    // combinational helpers
    logic [WHEEL_W-1:0]  avg;
    logic [SPEED_W-1:0]  front_ext;
    logic [SPEED_W-1:0]  gap;
    logic [SPEED_W-1:0]  margin_full;
    logic [MARGIN_W-1:0] margin;
    zone_t               zone_pick;
    logic                speed_sat;
    logic [RPROD_W-1:0]  rprod;
    logic [SPEED_W-1:0]  scaled_speed;
    logic                in_accept;
    logic                out_free;
    logic                out_load;

    ebsg_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword)
    );

    ebsg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign s_ready   = (uword.op == UOP_WAIT);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (uword.op == UOP_OUT) && out_free;

    // average of the two wheels, one extra bit for the carry then halve
    assign avg = WHEEL_W'(({1'b0, right_reg} + {1'b0, left_reg}) >> 1);

    assign front_ext   = SPEED_W'(front_reg);
    assign gap         = warn_reg - brake_reg;
    // only used in the warning zone, where braking < front so it fits 12 bits
    assign margin_full = front_ext - brake_reg;
    assign margin      = margin_full[MARGIN_W-1:0];

    // warning speed: saturate, else product / 100 as (product / 4) / 25
    assign speed_sat    = (prod_reg >= SPEED_SAT_LIMIT);
    assign rprod        = RPROD_W'(prod_reg[SCALE_IN_W+1:2]) * RPROD_W'(SLOPE_RECIP);
    assign scaled_speed = rprod[RECIP_SHIFT+SPEED_W-1:RECIP_SHIFT];

    // zone priority: clear, warning, braking, otherwise none
    always_comb begin
        if (front_ext > warn_reg && speed_reg != '0) begin
            zone_pick = ZONE_CLEAR;
        end else if (front_ext <= warn_reg && front_ext > brake_reg) begin
            zone_pick = ZONE_WARN;
        end else if (front_ext < brake_reg) begin
            zone_pick = ZONE_STOP;
        end else begin
            zone_pick = ZONE_NONE;
        end
    end

    // flags for the jump conditions
    always_comb begin
        flags.in_valid  = s_valid;
        flags.is_clear  = (zone_pick == ZONE_CLEAR);
        flags.not_warn  = (zone_reg != ZONE_WARN);
        flags.no_gap    = (warn_reg <= brake_reg);
        flags.div_busy  = div_busy;
        flags.out_free  = out_free;
    end

    // divider operands: slope needs (speed*200 + gap) / (2*gap)
    assign div_start = (uword.op == UOP_LDS) && !flags.no_gap;
    assign div_num   = DIV_NUM_W'(speed_reg) * DIV_NUM_W'(SLOPE_SCALE_X2)
                     + DIV_NUM_W'(gap);
    assign div_den   = {gap, 1'b0};

    // datapath next state, one operation per control word
    always_comb begin
        front_next  = front_reg;
        right_next  = right_reg;
        left_next   = left_reg;
        bprod_next  = bprod_reg;
        wprod_next  = wprod_reg;
        brake_next  = brake_reg;
        warn_next   = warn_reg;
        prod_next   = prod_reg;
        zone_next   = zone_reg;
        stop_next   = stop_reg;
        speed_next  = speed_reg;
        slope_next  = slope_reg;
        object_next = object_reg;
        buzzer_next = buzzer_reg;
        case (uword.op)
            UOP_WAIT: begin
                if (in_accept) begin
                    front_next = s_front_distance;
                    right_next = s_right_wheel_speed;
                    left_next  = s_left_wheel_speed;
                    if (s_command_valid) begin
                        speed_next = s_new_speed;
                    end
                end
            end
            UOP_MUL: begin
                bprod_next = FPROD_W'(brake_factor_reg) * FPROD_W'(avg);
                wprod_next = FPROD_W'(warn_factor_reg) * FPROD_W'(avg);
            end
            UOP_SAT: begin
                brake_next = (|bprod_reg[FPROD_W-1:SPEED_W]) ? SPEED_MAX
                                                             : bprod_reg[SPEED_W-1:0];
                warn_next  = (|wprod_reg[FPROD_W-1:SPEED_W]) ? SPEED_MAX
                                                             : wprod_reg[SPEED_W-1:0];
            end
            UOP_ZONE: begin
                zone_next = zone_pick;
                stop_next = (zone_pick == ZONE_STOP);
                case (zone_pick)
                    ZONE_CLEAR: begin
                        buzzer_next = 1'b0;
                    end
                    ZONE_WARN: begin
                        object_next = front_reg;
                        buzzer_next = 1'b1;
                    end
                    ZONE_STOP: begin
                        buzzer_next = 1'b1;
                        speed_next  = '0;
                    end
                    default: begin
                        // past the last object seen and at rest
                        if (front_reg > object_reg && speed_reg == '0) begin
                            buzzer_next = 1'b0;
                        end
                    end
                endcase
            end
            UOP_MULS: begin
                prod_next = PROD_W'(slope_reg) * PROD_W'(margin);
            end
            UOP_LDQ: begin
                speed_next = speed_sat ? SPEED_MAX : scaled_speed;
            end
            UOP_LDS: begin
                if (flags.no_gap) begin
                    slope_next = '0;
                end
            end
            UOP_WB: begin
                slope_next = div_quot[SLOPE_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brake_factor_reg <= BRAKE_FACTOR_RST;
            warn_factor_reg  <= WARN_FACTOR_RST;
            speed_reg        <= '0;
            slope_reg        <= '0;
            object_reg       <= '0;
            buzzer_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_BRAKE_FACTOR: brake_factor_reg <= cfg_wdata;
                    REG_WARN_FACTOR:  warn_factor_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            speed_reg   <= speed_next;
            slope_reg   <= slope_next;
            object_reg  <= object_next;
            buzzer_reg  <= buzzer_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        front_reg <= front_next;
        right_reg <= right_next;
        left_reg  <= left_next;
        bprod_reg <= bprod_next;
        wprod_reg <= wprod_next;
        brake_reg <= brake_next;
        warn_reg  <= warn_next;
        prod_reg  <= prod_next;
        zone_reg  <= zone_next;
        stop_reg  <= stop_next;
        if (out_load) begin
            m_speed_reg  <= speed_reg;
            m_zone_reg   <= zone_reg;
            m_buzzer_reg <= buzzer_reg;
            m_stop_reg   <= stop_reg;
            m_brake_reg  <= brake_reg;
            m_warn_reg   <= warn_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_drive_speed      = m_speed_reg;
    assign m_zone             = m_zone_reg;
    assign m_buzzer_on        = m_buzzer_reg;
    assign m_stop_request     = m_stop_reg;
    assign m_braking_distance = m_brake_reg;
    assign m_warning_distance = m_warn_reg;

    // a stop beat always carries the braking zone and zero speed
    a_stop_means_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stop_request |-> m_zone == ZONE_STOP && m_drive_speed == '0)
        else $error("stop request without braking zone and zero speed");

    // warning beats always sound the buzzer
    a_warn_buzzer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zone == ZONE_WARN |-> m_buzzer_on)
        else $error("warning zone with buzzer off");

    // the divider is never left running while the block waits for input
    a_div_idle_on_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_busy)
        else $error("divider busy while waiting for input");

    // one item at a time: no back-to-back accepts
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

endmodule
